>>> rtl/core/ztt_pkg.sv
// ----------------------------------------------------------------------------
// ztt_pkg
// Shared types and constants of the zone text tokenizer: item layouts,
// configuration set, byte classes and result codes.
// ----------------------------------------------------------------------------
package ztt_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_OPEN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_CLOSE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_OPEN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_CLOSE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMENT_CHAR   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESC_BYTE       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_CHARS    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_ON_QUOTE = 3'd7;

    localparam logic [7:0]  RST_STRING_OPEN    = 8'd34;
    localparam logic [7:0]  RST_STRING_CLOSE   = 8'd34;
    localparam logic [7:0]  RST_GROUP_OPEN     = 8'd40;
    localparam logic [7:0]  RST_GROUP_CLOSE    = 8'd41;
    localparam logic [7:0]  RST_COMMENT_CHAR   = 8'd59;
    localparam logic [7:0]  RST_ESC_BYTE       = 8'd92;
    localparam logic [23:0] RST_BLANK_CHARS    = 24'h20090D;
    localparam logic        RST_SPLIT_ON_QUOTE = 1'b0;

    // Queue between classifier and state machine
    localparam int QUEUE_DEPTH_DEF = 2;

    // Character constants
    localparam logic [7:0]  CHAR_NL   = 8'd10;
    localparam logic [7:0]  CHAR_0    = 8'h30;
    localparam logic [7:0]  CHAR_2    = 8'h32;
    localparam logic [7:0]  CHAR_9    = 8'h39;
    localparam logic [12:0] BYTE_MAX  = 13'd255;

    // Token kinds
    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_STRING  = 2'd1;
    localparam logic [1:0] KIND_COMMENT = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_GROUP         = 3'd1;
    localparam logic [2:0] ERR_STRAY_QUOTE   = 3'd2;
    localparam logic [2:0] ERR_OPEN_STRING   = 3'd3;
    localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd4;
    localparam logic [2:0] ERR_ESC_AT_END    = 3'd5;
    localparam logic [2:0] ERR_GROUP_AT_END  = 3'd6;

    typedef struct packed {
        logic [7:0]  string_open;
        logic [7:0]  string_close;
        logic [7:0]  group_open;
        logic [7:0]  group_close;
        logic [7:0]  comment_char;
        logic [7:0]  esc_byte;
        logic [23:0] blank_chars;
        logic        split_on_quote;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_start;
        logic       token_end;
        logic [1:0] token_kind;
        logic       blank_before;
        logic       line_end;
        logic [2:0] error_code;
    } token_item_t;

    // Classified byte: raw match flags, priority is applied by the back end
    typedef struct packed {
        logic [7:0] chr;
        logic       eos;
        logic       is_nl;
        logic       is_esc;
        logic       is_blank;
        logic       is_cmt;
        logic       is_gclose;
        logic       is_gopen;
        logic       is_sopen;
        logic       is_sclose;
    } class_item_t;

endpackage

>>> rtl/core/ztt_stream_if.sv
// ----------------------------------------------------------------------------
// ztt_stream_if
// Valid/ready stream channel carrying one item per transfer.
// ----------------------------------------------------------------------------
interface ztt_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/core/ztt_front.sv
// ----------------------------------------------------------------------------
// ztt_front
// Accepts text items and classifies each byte against the configured
// delimiter, escape, comment and blank bytes.
// ----------------------------------------------------------------------------
module ztt_front (
    input  ztt_pkg::cfg_t        cfg,
    ztt_stream_if.sink           text,
    input  logic                 queue_full,
    output logic                 push,
    output ztt_pkg::class_item_t push_item
);
    import ztt_pkg::*;

    logic [7:0] chr;

    assign chr        = text.data.in_byte;
    assign text.ready = !queue_full;
    assign push       = text.valid && !queue_full;

    always_comb
    begin
        push_item           = '0;
        push_item.chr       = chr;
        push_item.eos       = text.data.end_of_stream;
        push_item.is_nl     = (chr == CHAR_NL);
        push_item.is_esc    = (chr == cfg.esc_byte);
        push_item.is_blank  = (chr == cfg.blank_chars[7:0]) ||
                              (chr == cfg.blank_chars[15:8]) ||
                              (chr == cfg.blank_chars[23:16]);
        push_item.is_cmt    = (chr == cfg.comment_char);
        push_item.is_gclose = (chr == cfg.group_close);
        push_item.is_gopen  = (chr == cfg.group_open);
        push_item.is_sopen  = (chr == cfg.string_open);
        push_item.is_sclose = (chr == cfg.string_close);
    end

endmodule

>>> rtl/core/ztt_queue.sv
// ----------------------------------------------------------------------------
// ztt_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module ztt_queue #(
    parameter int DEPTH = ztt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ztt_pkg::class_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output ztt_pkg::class_item_t head,
    output logic                 nonempty
);
    import ztt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    class_item_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/ztt_back.sv
// ----------------------------------------------------------------------------
// ztt_back
// Character state machine: words, strings, comments, escapes and groups.
// One classified item per cycle unless the token output stalls, result held in an output register.
// ----------------------------------------------------------------------------
module ztt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 split_on_quote,
    input  ztt_pkg::class_item_t head,
    input  logic                 nonempty,
    output logic                 pop,
    ztt_stream_if.source         token
);
    import ztt_pkg::*;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_WORD = 3'd1;
    localparam logic [2:0] MODE_STR  = 3'd2;
    localparam logic [2:0] MODE_CMT  = 3'd3;
    localparam logic [2:0] MODE_ESC  = 3'd4;
    localparam logic [2:0] MODE_DIG1 = 3'd5;
    localparam logic [2:0] MODE_DIG2 = 3'd6;

    logic [2:0]  mode_reg, mode_next;
    logic        owner_reg, owner_next;     // 1: escape belongs to a string
    logic        group_reg, group_next;
    logic [8:0]  evalue_reg, evalue_next;
    logic        blank_reg, blank_next;
    logic        tok_valid_reg;
    token_item_t tok_data_reg;

    token_item_t res;
    logic [2:0]  err;
    logic        run_idle;
    logic        is_digit;
    logic        is_low_digit;
    logic [12:0] ev_sum;
    logic [2:0]  esc_back;

    assign pop         = nonempty && (!tok_valid_reg || token.ready);
    assign token.valid = tok_valid_reg;
    assign token.data  = tok_data_reg;

    assign is_digit     = (head.chr >= CHAR_0) && (head.chr <= CHAR_9);
    assign is_low_digit = (head.chr >= CHAR_0) && (head.chr <= CHAR_2);
    assign ev_sum       = ({4'd0, evalue_reg} << 3) + ({4'd0, evalue_reg} << 1) +
                          {5'd0, head.chr - CHAR_0};
    assign esc_back     = owner_reg ? MODE_STR : MODE_WORD;

    always_comb
    begin
        res         = '0;
        err         = ERR_NONE;
        run_idle    = 1'b0;
        mode_next   = mode_reg;
        owner_next  = owner_reg;
        group_next  = group_reg;
        evalue_next = evalue_reg;
        blank_next  = blank_reg;

        if (head.eos)
        begin
            case (mode_reg)
                MODE_STR:             err = ERR_OPEN_STRING;
                MODE_ESC:             err = ERR_ESC_AT_END;
                MODE_DIG1, MODE_DIG2: err = ERR_BAD_ESCAPE;
                default:
                begin
                    if (group_reg)
                    begin
                        err = ERR_GROUP_AT_END;
                    end
                    else
                    begin
                        if (mode_reg inside {MODE_WORD, MODE_CMT})
                        begin
                            res.token_end  = 1'b1;
                            res.token_kind = (mode_reg == MODE_CMT) ? KIND_COMMENT : KIND_WORD;
                            res.line_end   = 1'b1;
                        end
                        mode_next   = MODE_IDLE;
                        evalue_next = '0;
                        blank_next  = 1'b0;
                    end
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_WORD:
                begin
                    res.token_kind = KIND_WORD;
                    if (head.is_esc)
                    begin
                        owner_next = 1'b0;
                        mode_next  = MODE_ESC;
                    end
                    else if (!(head.is_nl || head.is_blank || head.is_cmt ||
                               head.is_gclose || head.is_gopen || head.is_sopen))
                    begin
                        res.out_byte   = head.chr;
                        res.byte_valid = 1'b1;
                    end
                    else if (head.is_sopen && !split_on_quote)
                    begin
                        err = ERR_STRAY_QUOTE;
                    end
                    else
                    begin
                        res.token_end = 1'b1;
                        mode_next     = MODE_IDLE;
                        if (head.is_blank && !head.is_nl)
                        begin
                            blank_next = 1'b1;
                        end
                        else
                        begin
                            run_idle = 1'b1;    // ending byte may start a token
                        end
                    end
                end
                MODE_STR:
                begin
                    res.token_kind = KIND_STRING;
                    if (head.is_sclose)
                    begin
                        res.token_end = 1'b1;
                        mode_next     = MODE_IDLE;
                    end
                    else if (head.is_esc)
                    begin
                        owner_next = 1'b1;
                        mode_next  = MODE_ESC;
                    end
                    else if (head.is_nl)
                    begin
                        err = ERR_OPEN_STRING;
                    end
                    else
                    begin
                        res.out_byte   = head.chr;
                        res.byte_valid = 1'b1;
                    end
                end
                MODE_CMT:
                begin
                    res.token_kind = KIND_COMMENT;
                    if (head.is_nl)
                    begin
                        res.token_end = 1'b1;
                        mode_next     = MODE_IDLE;
                        if (group_reg)
                        begin
                            blank_next = 1'b1;
                        end
                        else
                        begin
                            res.line_end = 1'b1;
                            blank_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        res.out_byte   = head.chr;
                        res.byte_valid = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    res.token_kind = owner_reg ? KIND_STRING : KIND_WORD;
                    if (is_low_digit)
                    begin
                        evalue_next = {1'b0, head.chr - CHAR_0};
                        mode_next   = MODE_DIG1;
                    end
                    else
                    begin
                        res.out_byte   = head.chr;
                        res.byte_valid = 1'b1;
                        mode_next      = esc_back;
                    end
                end
                MODE_DIG1:
                begin
                    res.token_kind = owner_reg ? KIND_STRING : KIND_WORD;
                    if (!is_digit)
                    begin
                        err = ERR_BAD_ESCAPE;
                    end
                    else
                    begin
                        evalue_next = ev_sum[8:0];
                        mode_next   = MODE_DIG2;
                    end
                end
                MODE_DIG2:
                begin
                    res.token_kind = owner_reg ? KIND_STRING : KIND_WORD;
                    if (!is_digit || (ev_sum > BYTE_MAX))
                    begin
                        err = ERR_BAD_ESCAPE;
                    end
                    else
                    begin
                        res.out_byte   = ev_sum[7:0];
                        res.byte_valid = 1'b1;
                        evalue_next    = '0;
                        mode_next      = esc_back;
                    end
                end
                default: run_idle = 1'b1;
            endcase

            if (run_idle)
            begin
                if (head.is_nl)
                begin
                    if (group_next)
                    begin
                        blank_next = 1'b1;
                    end
                    else
                    begin
                        res.line_end = 1'b1;
                        blank_next   = 1'b0;
                    end
                end
                else if (head.is_esc)
                begin
                    res.token_start  = 1'b1;
                    res.token_kind   = KIND_WORD;
                    res.blank_before = blank_next;
                    blank_next       = 1'b0;
                    owner_next       = 1'b0;
                    mode_next        = MODE_ESC;
                end
                else if (head.is_blank)
                begin
                    blank_next = 1'b1;
                end
                else if (head.is_cmt)
                begin
                    res.token_start  = 1'b1;
                    res.token_kind   = KIND_COMMENT;
                    res.blank_before = blank_next;
                    blank_next       = 1'b0;
                    res.out_byte     = head.chr;
                    res.byte_valid   = 1'b1;
                    mode_next        = MODE_CMT;
                end
                else if (head.is_gclose)
                begin
                    if (group_next)
                    begin
                        group_next = 1'b0;
                    end
                    else
                    begin
                        err = ERR_GROUP;
                    end
                end
                else if (head.is_gopen)
                begin
                    if (!group_next)
                    begin
                        group_next = 1'b1;
                    end
                    else
                    begin
                        err = ERR_GROUP;
                    end
                end
                else if (head.is_sopen)
                begin
                    res.token_start  = 1'b1;
                    res.token_kind   = KIND_STRING;
                    res.blank_before = blank_next;
                    blank_next       = 1'b0;
                    mode_next        = MODE_STR;
                end
                else
                begin
                    res.token_start  = 1'b1;
                    res.token_kind   = KIND_WORD;
                    res.blank_before = blank_next;
                    blank_next       = 1'b0;
                    res.out_byte     = head.chr;
                    res.byte_valid   = 1'b1;
                    mode_next        = MODE_WORD;
                end
            end
        end

        // any error abandons the token and clears the group
        if (err != ERR_NONE)
        begin
            res            = '0;
            res.error_code = err;
            mode_next      = MODE_IDLE;
            owner_next     = 1'b0;
            group_next     = 1'b0;
            evalue_next    = '0;
            blank_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            owner_reg     <= 1'b0;
            group_reg     <= 1'b0;
            evalue_reg    <= '0;
            blank_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg   <= mode_next;
                owner_reg  <= owner_next;
                group_reg  <= group_next;
                evalue_reg <= evalue_next;
                blank_reg  <= blank_next;
            end
            if (pop)
            begin
                tok_valid_reg <= 1'b1;
            end
            else if (token.ready)
            begin
                tok_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tok_data_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_err_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (err != ERR_NONE) |=> (mode_reg == MODE_IDLE) && !group_reg && !blank_reg)
        else $error("error item left scanner state behind");

    a_err_result_bare: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_reg && (tok_data_reg.error_code != ERR_NONE) |->
            !tok_data_reg.byte_valid && !tok_data_reg.token_start &&
            !tok_data_reg.token_end && !tok_data_reg.line_end)
        else $error("error result carries token marks");

    a_blank_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_reg && tok_data_reg.blank_before |-> tok_data_reg.token_start)
        else $error("blank_before without token_start");

    a_no_eol_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        pop && res.line_end |-> !group_reg)
        else $error("line end reported inside open group");

    a_pop_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> tok_valid_reg)
        else $error("popped item not presented at output");
`endif

endmodule

>>> rtl/core/zone_text_tokenizer_core.sv
// An accepted text item is written into the queue, then popped into the output
// register. Throughput: one item per cycle while the token output is not stalled,
// set by the back-end character state machine taking one classified byte per cycle.
// Reset: asynchronous, active low; configuration returns to its defaults, the
// scanner goes idle with no group open, and the queue and output register empty.
// ----------------------------------------------------------------------------
// zone_text_tokenizer_core
// Zone text tokenizer: configuration registers, byte classifier front end,
// item queue and character state machine back end.
// ----------------------------------------------------------------------------
module zone_text_tokenizer_core #(
    parameter int QUEUE_DEPTH = ztt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ztt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ztt_pkg::CFG_DATA_W-1:0]   cfg_data,
    ztt_stream_if.sink                       text,
    ztt_stream_if.source                     token
);
    import ztt_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        push;
    class_item_t push_item;
    logic        queue_full;
    logic        pop;
    class_item_t head;
    logic        nonempty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_STRING_OPEN:    cfg_next.string_open    = cfg_data[7:0];
                CFG_STRING_CLOSE:   cfg_next.string_close   = cfg_data[7:0];
                CFG_GROUP_OPEN:     cfg_next.group_open     = cfg_data[7:0];
                CFG_GROUP_CLOSE:    cfg_next.group_close    = cfg_data[7:0];
                CFG_COMMENT_CHAR:   cfg_next.comment_char   = cfg_data[7:0];
                CFG_ESC_BYTE:       cfg_next.esc_byte       = cfg_data[7:0];
                CFG_BLANK_CHARS:    cfg_next.blank_chars    = cfg_data[23:0];
                CFG_SPLIT_ON_QUOTE: cfg_next.split_on_quote = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.string_open    <= RST_STRING_OPEN;
            cfg_reg.string_close   <= RST_STRING_CLOSE;
            cfg_reg.group_open     <= RST_GROUP_OPEN;
            cfg_reg.group_close    <= RST_GROUP_CLOSE;
            cfg_reg.comment_char   <= RST_COMMENT_CHAR;
            cfg_reg.esc_byte       <= RST_ESC_BYTE;
            cfg_reg.blank_chars    <= RST_BLANK_CHARS;
            cfg_reg.split_on_quote <= RST_SPLIT_ON_QUOTE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ztt_front u_front (
        .cfg        (cfg_reg),
        .text       (text),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    ztt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .nonempty  (nonempty)
    );

    ztt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .split_on_quote (cfg_reg.split_on_quote),
        .head           (head),
        .nonempty       (nonempty),
        .pop            (pop),
        .token          (token)
    );

endmodule

>>> verif/ztt_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ztt_token_checker
// Watches the register port and both streams of the zone text tokenizer.
// Every accepted text item is run through a local copy of the scanner to
// produce the token item it should cause. Each accepted token item is then
// compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module ztt_token_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ztt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ztt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            text_valid,
    input  logic                            text_ready,
    input  ztt_pkg::text_item_t             text_data,
    input  logic                            token_valid,
    input  logic                            token_ready,
    input  ztt_pkg::token_item_t            token_data,
    output int                              errors,
    output int                              pending,
    output int                              checked,
    output logic [7:0]                      codes_seen
);
    import ztt_pkg::*;

    localparam logic [2:0] SCAN_IDLE    = 3'd0;
    localparam logic [2:0] SCAN_WORD    = 3'd1;
    localparam logic [2:0] SCAN_STRING  = 3'd2;
    localparam logic [2:0] SCAN_COMMENT = 3'd3;
    localparam logic [2:0] SCAN_ESCAPE  = 3'd4;
    localparam logic [2:0] SCAN_DIGIT1  = 3'd5;
    localparam logic [2:0] SCAN_DIGIT2  = 3'd6;

    localparam cfg_t CFG_DEFAULT = '{RST_STRING_OPEN, RST_STRING_CLOSE, RST_GROUP_OPEN,
                                     RST_GROUP_CLOSE, RST_COMMENT_CHAR, RST_ESC_BYTE,
                                     RST_BLANK_CHARS, RST_SPLIT_ON_QUOTE};

    cfg_t        cfg;
    logic [2:0]  scan;
    logic        esc_in_string;
    logic        grp;
    logic [8:0]  esc_acc;
    logic        blank_seen;
    token_item_t tok;
    token_item_t tokens_due [$];

    function automatic logic is_blank(input logic [7:0] b);
        return b == cfg.blank_chars[7:0] || b == cfg.blank_chars[15:8] ||
               b == cfg.blank_chars[23:16];
    endfunction

    // Errors wipe the item and drop any open token and group
    function automatic void abort_scan(input logic [2:0] code);
        tok = '0;
        tok.error_code = code;
        scan = SCAN_IDLE;
        esc_in_string = 1'b0;
        grp = 1'b0;
        esc_acc = '0;
        blank_seen = 1'b0;
    endfunction

    function automatic void open_token(input logic [1:0] kind);
        tok.token_start = 1'b1;
        tok.token_kind = kind;
        tok.blank_before = blank_seen;
        blank_seen = 1'b0;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        tok.out_byte = b;
        tok.byte_valid = 1'b1;
    endfunction

    // Newline inside a group is just a blank
    function automatic void take_newline();
        if (grp)
            blank_seen = 1'b1;
        else
        begin
            tok.line_end = 1'b1;
            blank_seen = 1'b0;
        end
    endfunction

    function automatic void idle_byte(input logic [7:0] b);
        if (b == CHAR_NL)
            take_newline();
        else if (b == cfg.esc_byte)
        begin
            open_token(KIND_WORD);
            esc_in_string = 1'b0;
            scan = SCAN_ESCAPE;
        end
        else if (is_blank(b))
            blank_seen = 1'b1;
        else if (b == cfg.comment_char)
        begin
            open_token(KIND_COMMENT);
            put_byte(b);
            scan = SCAN_COMMENT;
        end
        else if (b == cfg.group_close)
        begin
            if (grp)
                grp = 1'b0;
            else
                abort_scan(ERR_GROUP);
        end
        else if (b == cfg.group_open)
        begin
            if (!grp)
                grp = 1'b1;
            else
                abort_scan(ERR_GROUP);
        end
        else if (b == cfg.string_open)
        begin
            open_token(KIND_STRING);
            scan = SCAN_STRING;
        end
        else
        begin
            open_token(KIND_WORD);
            put_byte(b);
            scan = SCAN_WORD;
        end
    endfunction

    function automatic token_item_t scan_byte(input logic [7:0] b, input logic eos);
        logic [2:0] back;
        int         v;
        tok = '0;
        back = esc_in_string ? SCAN_STRING : SCAN_WORD;
        if (eos)
        begin
            case (scan)
                SCAN_STRING: abort_scan(ERR_OPEN_STRING);
                SCAN_ESCAPE: abort_scan(ERR_ESC_AT_END);
                SCAN_DIGIT1, SCAN_DIGIT2: abort_scan(ERR_BAD_ESCAPE);
                default:
                begin
                    if (grp)
                        abort_scan(ERR_GROUP_AT_END);
                    else
                    begin
                        if (scan == SCAN_WORD || scan == SCAN_COMMENT)
                        begin
                            tok.token_end = 1'b1;
                            tok.token_kind = (scan == SCAN_COMMENT) ? KIND_COMMENT : KIND_WORD;
                            tok.line_end = 1'b1;
                        end
                        scan = SCAN_IDLE;
                        esc_acc = '0;
                        blank_seen = 1'b0;
                    end
                end
            endcase
            return tok;
        end
        case (scan)
            SCAN_IDLE: idle_byte(b);
            SCAN_WORD:
            begin
                tok.token_kind = KIND_WORD;
                if (b == cfg.esc_byte)
                begin
                    esc_in_string = 1'b0;
                    scan = SCAN_ESCAPE;
                end
                else if (b != CHAR_NL && !is_blank(b) && b != cfg.comment_char &&
                         b != cfg.group_close && b != cfg.group_open && b != cfg.string_open)
                    put_byte(b);
                else if (b == cfg.string_open && !cfg.split_on_quote)
                    abort_scan(ERR_STRAY_QUOTE);
                else
                begin
                    // word ends here; the same item may open the next token
                    tok.token_end = 1'b1;
                    scan = SCAN_IDLE;
                    if (is_blank(b) && b != CHAR_NL)
                        blank_seen = 1'b1;
                    else
                        idle_byte(b);
                end
            end
            SCAN_STRING:
            begin
                tok.token_kind = KIND_STRING;
                if (b == cfg.string_close)
                begin
                    tok.token_end = 1'b1;
                    scan = SCAN_IDLE;
                end
                else if (b == cfg.esc_byte)
                begin
                    esc_in_string = 1'b1;
                    scan = SCAN_ESCAPE;
                end
                else if (b == CHAR_NL)
                    abort_scan(ERR_OPEN_STRING);
                else
                    put_byte(b);
            end
            SCAN_COMMENT:
            begin
                tok.token_kind = KIND_COMMENT;
                if (b == CHAR_NL)
                begin
                    tok.token_end = 1'b1;
                    scan = SCAN_IDLE;
                    take_newline();
                end
                else
                    put_byte(b);
            end
            default:
            begin
                tok.token_kind = esc_in_string ? KIND_STRING : KIND_WORD;
                if (scan == SCAN_ESCAPE)
                begin
                    if (b >= CHAR_0 && b <= CHAR_2)
                    begin
                        esc_acc = 9'(b - CHAR_0);
                        scan = SCAN_DIGIT1;
                    end
                    else
                    begin
                        put_byte(b);
                        scan = back;
                    end
                end
                else if (b < CHAR_0 || b > CHAR_9)
                    abort_scan(ERR_BAD_ESCAPE);
                else if (scan == SCAN_DIGIT1)
                begin
                    esc_acc = 9'(esc_acc * 10 + (b - CHAR_0));
                    scan = SCAN_DIGIT2;
                end
                else
                begin
                    v = esc_acc * 10 + (b - CHAR_0);
                    if (v > BYTE_MAX)
                        abort_scan(ERR_BAD_ESCAPE);
                    else
                    begin
                        put_byte(8'(v));
                        esc_acc = '0;
                        scan = back;
                    end
                end
            end
        endcase
        return tok;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: token item %0d, %s: expected %0h, actual %0h",
                     $time, checked, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_item_t want;
        if (!rst_n)
        begin
            cfg = CFG_DEFAULT;
            scan = SCAN_IDLE;
            esc_in_string = 1'b0;
            grp = 1'b0;
            esc_acc = '0;
            blank_seen = 1'b0;
            tokens_due.delete();
            errors = 0;
            pending = 0;
            checked = 0;
            codes_seen = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STRING_OPEN:    cfg.string_open = cfg_data[7:0];
                    CFG_STRING_CLOSE:   cfg.string_close = cfg_data[7:0];
                    CFG_GROUP_OPEN:     cfg.group_open = cfg_data[7:0];
                    CFG_GROUP_CLOSE:    cfg.group_close = cfg_data[7:0];
                    CFG_COMMENT_CHAR:   cfg.comment_char = cfg_data[7:0];
                    CFG_ESC_BYTE:       cfg.esc_byte = cfg_data[7:0];
                    CFG_BLANK_CHARS:    cfg.blank_chars = cfg_data;
                    CFG_SPLIT_ON_QUOTE: cfg.split_on_quote = cfg_data[0];
                    default: ;
                endcase
            end
            if (text_valid && text_ready)
            begin
                want = scan_byte(text_data.in_byte, text_data.end_of_stream);
                codes_seen[want.error_code] = 1'b1;
                tokens_due.push_back(want);
            end
            if (token_valid && token_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: token item with none due: expected nothing, actual %p",
                             $time, token_data);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("out_byte", want.out_byte, token_data.out_byte);
                    check_field("byte_valid", want.byte_valid, token_data.byte_valid);
                    check_field("token_start", want.token_start, token_data.token_start);
                    check_field("token_end", want.token_end, token_data.token_end);
                    check_field("token_kind", want.token_kind, token_data.token_kind);
                    check_field("blank_before", want.blank_before, token_data.blank_before);
                    check_field("line_end", want.line_end, token_data.line_end);
                    check_field("error_code", want.error_code, token_data.error_code);
                    checked++;
                end
            end
            pending = tokens_due.size();
        end
    end

endmodule

>>> verif/zone_text_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zone_text_tokenizer_core_tb
// Feeds the tokenizer a short hand-picked byte sequence under the reset
// settings, then random zone-file style lines (words, strings, comments,
// escapes, groups, noise and end-of-stream marks) under several register
// settings. Both streams idle and stall at random; the checker does the rest.
// ----------------------------------------------------------------------------
module zone_text_tokenizer_core_tb;
    import ztt_pkg::*;

    localparam int EOS_MARK    = 256;
    localparam int PHASE_ITEMS = 85;
    localparam int CYCLE_LIMIT = 200000;

    localparam cfg_t CFG_DEFAULT = '{RST_STRING_OPEN, RST_STRING_CLOSE, RST_GROUP_OPEN,
                                     RST_GROUP_CLOSE, RST_COMMENT_CHAR, RST_ESC_BYTE,
                                     RST_BLANK_CHARS, RST_SPLIT_ON_QUOTE};

    // Reset settings: extremes of the byte, each error code but the bad escape and the odd cases
    int directed_seq [23] = '{8'h00, 8'hFF, RST_ESC_BYTE, "2", "5", "5",
                              RST_COMMENT_CHAR, CHAR_NL,
                              RST_GROUP_OPEN, CHAR_NL, RST_GROUP_CLOSE, RST_GROUP_CLOSE,
                              RST_STRING_OPEN, CHAR_NL,
                              "w", RST_STRING_OPEN,
                              RST_ESC_BYTE, CHAR_NL, EOS_MARK,
                              RST_ESC_BYTE, EOS_MARK,
                              RST_GROUP_OPEN, EOS_MARK};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ztt_stream_if #(.T(text_item_t))  text_ch ();
    ztt_stream_if #(.T(token_item_t)) token_ch ();

    int         errors;
    int         pending;
    int         checked;
    logic [7:0] codes_seen;
    int         cycles;

    cfg_t cur;
    int   items_sent;
    int   burst_left;
    int   phases;
    logic group_held;

    zone_text_tokenizer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text      (text_ch),
        .token     (token_ch)
    );

    ztt_token_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .text_valid  (text_ch.valid),
        .text_ready  (text_ch.ready),
        .text_data   (text_ch.data),
        .token_valid (token_ch.valid),
        .token_ready (token_ch.ready),
        .token_data  (token_ch.data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .codes_seen  (codes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d token items still due", cycles, pending);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: stall density is redrawn at the end of each random span, zero included
    initial
    begin
        int stall_left;
        int stall_pct;
        int span;
        token_ch.ready = 1'b0;
        stall_left = 0;
        stall_pct = 0;
        span = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                span = $urandom_range(50, 200);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 50;
                endcase
            end
            span--;
            if (stall_left > 0)
            begin
                token_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                token_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    // One text item; EOS_MARK sends end of stream with a junk byte
    task automatic push_text(input int v);
        text_item_t it;
        if (burst_left == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        it.end_of_stream = (v == EOS_MARK);
        it.in_byte = (v == EOS_MARK) ? 8'($urandom) : 8'(v);
        text_ch.data <= it;
        text_ch.valid <= 1'b1;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic settle();
        text_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic load_config(input cfg_t c);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STRING_OPEN;
        cfg_data <= 24'(c.string_open);
        @(negedge clk);
        cfg_index <= CFG_STRING_CLOSE;
        cfg_data <= 24'(c.string_close);
        @(negedge clk);
        cfg_index <= CFG_GROUP_OPEN;
        cfg_data <= 24'(c.group_open);
        @(negedge clk);
        cfg_index <= CFG_GROUP_CLOSE;
        cfg_data <= 24'(c.group_close);
        @(negedge clk);
        cfg_index <= CFG_COMMENT_CHAR;
        cfg_data <= 24'(c.comment_char);
        @(negedge clk);
        cfg_index <= CFG_ESC_BYTE;
        cfg_data <= 24'(c.esc_byte);
        @(negedge clk);
        cfg_index <= CFG_BLANK_CHARS;
        cfg_data <= c.blank_chars;
        @(negedge clk);
        cfg_index <= CFG_SPLIT_ON_QUOTE;
        cfg_data <= 24'(c.split_on_quote);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur = c;
        phases++;
    endtask

    // A byte with no special meaning under the current settings
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == CHAR_NL || b == cur.esc_byte || b == cur.blank_chars[7:0] ||
               b == cur.blank_chars[15:8] || b == cur.blank_chars[23:16] ||
               b == cur.comment_char || b == cur.group_close || b == cur.group_open ||
               b == cur.string_open || b == cur.string_close);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return cur.blank_chars[8 * $urandom_range(0, 2) +: 8];
    endfunction

    task automatic send_escape();
        int v;
        push_text(cur.esc_byte);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                v = $urandom_range(0, 255);
                push_text(CHAR_0 + v / 100);
                push_text(CHAR_0 + (v / 10) % 10);
                push_text(CHAR_0 + v % 10);
            end
            4:
            begin
                // three digits but above 255
                v = $urandom_range(256, 299);
                push_text(CHAR_0 + v / 100);
                push_text(CHAR_0 + (v / 10) % 10);
                push_text(CHAR_0 + v % 10);
            end
            5:
            begin
                push_text(CHAR_0 + $urandom_range(0, 2));
                push_text(plain_byte());
            end
            default:
            begin
                do
                    v = $urandom_range(0, 255);
                while (v >= CHAR_0 && v <= CHAR_2);
                push_text(v);
            end
        endcase
    endtask

    task automatic send_word();
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 99) < 85)
                push_text(plain_byte());
            else
                send_escape();
        end
    endtask

    task automatic send_string();
        push_text(cur.string_open);
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(0, 4) != 0)
                push_text(plain_byte());
            else
                send_escape();
        end
        push_text(cur.string_close);
    endtask

    task automatic send_comment();
        int v;
        push_text(cur.comment_char);
        repeat ($urandom_range(0, 6))
        begin
            do
                v = $urandom_range(0, 255);
            while (v == CHAR_NL);
            push_text(v);
        end
        push_text(CHAR_NL);
    endtask

    // Mostly well-formed line; about one token in seven is noise
    task automatic send_line();
        int pick;
        repeat ($urandom_range(1, 5))
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                send_word();
            else if (pick < 14)
                send_string();
            else if (pick < 16)
            begin
                push_text(group_held ? cur.group_close : cur.group_open);
                group_held = !group_held;
            end
            else if (pick < 18)
                push_text($urandom_range(0, 255));
            else if (pick == 18)
                push_text($urandom_range(0, 1) ? cur.group_open : cur.group_close);
            else
            begin
                push_text(EOS_MARK);
                group_held = 1'b0;
            end
            // no blank sometimes, so a word runs straight into the next token
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 2)) push_text(blank_byte());
        end
        if (group_held && $urandom_range(0, 4) < 3)
        begin
            push_text(cur.group_close);
            group_held = 1'b0;
        end
        if ($urandom_range(0, 3) == 0)
            send_comment();
        else
            push_text(CHAR_NL);
    endtask

    initial
    begin
        cfg_t c;
        int   start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        text_ch.valid = 1'b0;
        text_ch.data = '0;
        cur = CFG_DEFAULT;
        items_sent = 0;
        burst_left = 0;
        phases = 0;
        group_held = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed_seq[i])
            push_text(directed_seq[i]);
        settle();

        for (int p = 0; p < 5; p++)
        begin
            c = CFG_DEFAULT;
            case (p)
                0: c.split_on_quote = 1'b1;
                1: c = '{8'h00, 8'hFF, 8'h01, 8'hFE, "#", "~", 24'h200B0C, 1'b0};
                2: c = '{"'", "'", "{", "}", "%", 8'h00, 24'hFFFFFF, 1'b1};
                3: c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 24'($urandom), 1'($urandom)};
                default: c.blank_chars = 24'h0A2000;
            endcase
            load_config(c);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                send_line();
            settle();
        end

        $display("Run covered %0d text items under %0d register settings, %0d token items checked",
                 items_sent, phases + 1, checked);
        $display("Error codes produced (one bit per code): %b", codes_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
